@@ sv/u2r_pkg.sv @@
// shared types, reciprocal constants and digit helpers for the unix time to rfc3339 converter
// no dependencies
package u2r_pkg;

  localparam logic signed [63:0] T_MIN = -64'sd62167219200;
  localparam logic signed [63:0] T_MAX = 64'sd253402300799;

  localparam int U_W = 39;
  localparam int Z_W = 22;

  localparam logic [32:0] DAY_M  = 33'(((64'd1 << 42) + 64'd674) / 64'd675);
  localparam int          DAY_K  = 42;
  localparam logic [9:0]  DAY_LO = 10'd675;
  localparam logic [21:0] Z_SHIFT = 22'd146037;

  localparam logic [22:0] ERA_M    = 23'(((64'd1 << 40) + 64'd146096) / 64'd146097);
  localparam int          ERA_K    = 40;
  localparam logic [22:0] ERA_DAYS = 23'd146097;

  localparam logic [18:0] D1460_M  = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
  localparam logic [18:0] D36524_M = 19'(((64'd1 << 34) + 64'd36523) / 64'd36524);
  localparam logic [18:0] D365_M   = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
  localparam logic [9:0]  D100Y_M  = 10'(((64'd1 << 16) + 64'd99) / 64'd100);
  localparam logic [11:0] D153_M   = 12'(((64'd1 << 19) + 64'd152) / 64'd153);
  localparam logic [17:0] HOUR_M   = 18'(((64'd1 << 29) + 64'd3599) / 64'd3600);
  localparam logic [12:0] MIN_M    = 13'(((64'd1 << 18) + 64'd59) / 64'd60);
  localparam logic [14:0] Y100_M   = 15'(((64'd1 << 21) + 64'd99) / 64'd100);
  localparam logic [17:0] DOE_LAST = 18'd146096;

  typedef struct packed {
    logic        ok;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } u2r_tm_t;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } u2r_date_t;

  // days before each march-based month
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] r;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // tens and ones of a value below 100
  function automatic logic [7:0] bcd2(input logic [6:0] v);
    logic [13:0] p;
    logic [3:0]  t;
    p = 14'(v) * 14'd103;
    t = 4'(p >> 10);
    return {t, 4'(v - 7'(t) * 7'd10)};
  endfunction

  function automatic logic [7:0] asc(input logic [3:0] d);
    return {4'h3, d};
  endfunction

endpackage

@@ sv/unix_seconds_to_rfc3339_utc_top.sv @@
// top level: signed unix seconds to binary utc date/time and rfc3339 text
// depends on u2r_pkg and u2r_civil
// throughput: one request per cycle, busy is always low; the pipeline has no stall
// reset: synchronous active-low rst_n clears the valid bits of every stage
// out_strobe marks each result for one cycle; the receiver cannot stall
module unix_seconds_to_rfc3339_utc_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_seconds_since_epoch,
  output logic        out_strobe,
  output logic        out_valid_res,
  output logic [13:0] out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day_of_month,
  output logic [4:0]  out_hour,
  output logic [5:0]  out_minute,
  output logic [5:0]  out_second,
  output logic [63:0] out_text_head,
  output logic [63:0] out_text_middle,
  output logic [31:0] out_text_tail
);

  logic        v1_r, v2_r, v3_r, v11_r, v12_r, v13_r;
  logic        civ_vld;
  logic        ok_nxt, ok1_r, ok2_r, ok3_r, ok4_r, ok5_r, ok6_r;
  logic [38:0] u1_r, u2_r;
  logic [64:0] day_prod;
  logic [21:0] q2_r, z3_r;
  logic [9:0]  r_nxt;
  logic [16:0] sod3_r, sod4_r;
  logic [34:0] hour_prod;
  logic [4:0]  hour4_r, hour5_r, hour6_r;
  logic [11:0] remh5_r, remh6_r;
  logic [24:0] min_prod;
  logic [5:0]  min6_r;
  u2r_pkg::u2r_tm_t  tm7_nxt;
  u2r_pkg::u2r_tm_t  tm_dly_r [4];
  u2r_pkg::u2r_tm_t  tm11_r, tm12_r;
  u2r_pkg::u2r_date_t civ_date;
  u2r_pkg::u2r_date_t dt11_r, dt12_r;
  logic [28:0] y100_prod;
  logic [6:0]  q100_r;
  logic [6:0]  r100;
  logic [7:0]  yh, yl, mo2, dd2, hh2, mi2, ss2;
  logic        ok13;

  assign busy = 1'b0;

  always_comb begin
    ok_nxt    = ($signed(in_seconds_since_epoch) >= u2r_pkg::T_MIN) &&
                ($signed(in_seconds_since_epoch) <= u2r_pkg::T_MAX);
    day_prod  = 65'(u1_r[38:7]) * 65'(u2r_pkg::DAY_M);
    r_nxt     = 10'(u2_r[38:7] - 32'(q2_r) * 32'(u2r_pkg::DAY_LO));
    hour_prod = 35'(sod3_r) * 35'(u2r_pkg::HOUR_M);
    min_prod  = 25'(remh5_r) * 25'(u2r_pkg::MIN_M);
    tm7_nxt.ok     = ok6_r;
    tm7_nxt.hour   = hour6_r;
    tm7_nxt.minute = min6_r;
    tm7_nxt.second = 6'(remh6_r - 12'(min6_r) * 12'd60);
    y100_prod = 29'(dt11_r.year) * 29'(u2r_pkg::Y100_M);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      v11_r <= 1'b0;
      v12_r <= 1'b0;
      v13_r <= 1'b0;
    end else begin
      v1_r  <= start && !busy;
      v2_r  <= v1_r;
      v3_r  <= v2_r;
      v11_r <= civ_vld;
      v12_r <= v11_r;
      v13_r <= v12_r;
    end
  end

  // time of day runs beside the date pipeline
  always_ff @(posedge clk) begin
    ok1_r   <= ok_nxt;
    u1_r    <= 39'(in_seconds_since_epoch - u2r_pkg::T_MIN);
    ok2_r   <= ok1_r;
    u2_r    <= u1_r;
    q2_r    <= 22'(day_prod >> u2r_pkg::DAY_K);
    ok3_r   <= ok2_r;
    sod3_r  <= {r_nxt, u2_r[6:0]};
    z3_r    <= q2_r + u2r_pkg::Z_SHIFT;
    ok4_r   <= ok3_r;
    sod4_r  <= sod3_r;
    hour4_r <= 5'(hour_prod >> 29);
    ok5_r   <= ok4_r;
    hour5_r <= hour4_r;
    remh5_r <= 12'(sod4_r - 17'(hour4_r) * 17'd3600);
    ok6_r   <= ok5_r;
    hour6_r <= hour5_r;
    remh6_r <= remh5_r;
    min6_r  <= 6'(min_prod >> 18);
    tm_dly_r[0] <= tm7_nxt;
    tm_dly_r[1] <= tm_dly_r[0];
    tm_dly_r[2] <= tm_dly_r[1];
    tm_dly_r[3] <= tm_dly_r[2];
    tm11_r  <= tm_dly_r[3];
    dt11_r  <= civ_date;
    q100_r  <= 7'(y100_prod >> 21);
    tm12_r  <= tm11_r;
    dt12_r  <= dt11_r;
  end

  u2r_civil u_civil (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (v3_r),
    .z       (z3_r),
    .out_vld (civ_vld),
    .date    (civ_date)
  );

  always_comb begin
    r100 = 7'(dt12_r.year - 14'(q100_r) * 14'd100);
    yh  = u2r_pkg::bcd2(7'(q100_r));
    yl  = u2r_pkg::bcd2(r100);
    mo2 = u2r_pkg::bcd2(7'(dt12_r.month));
    dd2 = u2r_pkg::bcd2(7'(dt12_r.day));
    hh2 = u2r_pkg::bcd2(7'(tm12_r.hour));
    mi2 = u2r_pkg::bcd2(7'(tm12_r.minute));
    ss2 = u2r_pkg::bcd2(7'(tm12_r.second));
    ok13 = tm12_r.ok;
  end

  always_ff @(posedge clk) begin
    out_valid_res    <= ok13;
    out_year         <= ok13 ? dt12_r.year : '0;
    out_month        <= ok13 ? dt12_r.month : '0;
    out_day_of_month <= ok13 ? dt12_r.day : '0;
    out_hour         <= ok13 ? tm12_r.hour : '0;
    out_minute       <= ok13 ? tm12_r.minute : '0;
    out_second       <= ok13 ? tm12_r.second : '0;
    out_text_head    <= ok13 ? {u2r_pkg::asc(yh[7:4]), u2r_pkg::asc(yh[3:0]),
                                u2r_pkg::asc(yl[7:4]), u2r_pkg::asc(yl[3:0]), 8'h2D,
                                u2r_pkg::asc(mo2[7:4]), u2r_pkg::asc(mo2[3:0]), 8'h2D} : '0;
    out_text_middle  <= ok13 ? {u2r_pkg::asc(dd2[7:4]), u2r_pkg::asc(dd2[3:0]), 8'h54,
                                u2r_pkg::asc(hh2[7:4]), u2r_pkg::asc(hh2[3:0]), 8'h3A,
                                u2r_pkg::asc(mi2[7:4]), u2r_pkg::asc(mi2[3:0])} : '0;
    out_text_tail    <= ok13 ? {8'h3A, u2r_pkg::asc(ss2[7:4]), u2r_pkg::asc(ss2[3:0]),
                                8'h5A} : '0;
  end

  assign out_strobe = v13_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##13 out_strobe)
    else $error("request did not produce a result after 13 cycles");

  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_valid_res |-> out_month >= 4'd1 && out_month <= 4'd12 &&
      out_day_of_month >= 5'd1 && out_day_of_month <= 5'd31)
    else $error("month or day out of range");

  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_valid_res |-> out_hour <= 5'd23 && out_minute <= 6'd59 &&
      out_second <= 6'd59)
    else $error("time of day out of range");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_valid_res |-> out_year == '0 && out_text_tail == '0 &&
      out_text_head == '0)
    else $error("invalid result carries data");

endmodule

@@ sv/u2r_civil.sv @@
// pipelined days-to-civil conversion: shifted day count to year, month and day
// depends on u2r_pkg
module u2r_civil (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_vld,
  input  logic [21:0]            z,
  output logic                   out_vld,
  output u2r_pkg::u2r_date_t     date
);

  logic [6:0]  vld_r;
  logic [44:0] era_prod;
  logic [4:0]  era1_r, era2_r, era3_r, era4_r, era5_r, era6_r;
  logic [21:0] z1_r;
  logic [17:0] doe_nxt, doe2_r, doe3_r, doe4_r;
  logic [36:0] a_prod, b_prod, y_prod;
  logic [17:0] num_nxt, num3_r;
  logic [8:0]  yoe4_r, yoe5_r, yoe6_r;
  logic [18:0] c_prod;
  logic [17:0] doy_sub;
  logic [8:0]  doy5_r, doy6_r;
  logic [10:0] mnum;
  logic [22:0] mp_prod;
  logic [3:0]  mp6_r;
  logic [14:0] yr_full;
  u2r_pkg::u2r_date_t date_nxt, date_r;

  always_comb begin
    era_prod = 45'(z) * 45'(u2r_pkg::ERA_M);
    doe_nxt  = 18'(23'(z1_r) - 23'(era1_r) * u2r_pkg::ERA_DAYS);
    a_prod   = 37'(doe2_r) * 37'(u2r_pkg::D1460_M);
    b_prod   = 37'(doe2_r) * 37'(u2r_pkg::D36524_M);
    num_nxt  = doe2_r - 18'(a_prod >> 29) + 18'(b_prod >> 34)
               - 18'(doe2_r == u2r_pkg::DOE_LAST);
    y_prod   = 37'(num3_r) * 37'(u2r_pkg::D365_M);
    c_prod   = 19'(yoe4_r) * 19'(u2r_pkg::D100Y_M);
    doy_sub  = 18'(yoe4_r) * 18'd365 + 18'(yoe4_r >> 2) - 18'(c_prod >> 16);
    mnum     = 11'(doy5_r) * 11'd5 + 11'd2;
    mp_prod  = 23'(mnum) * 23'(u2r_pkg::D153_M);
    yr_full  = 15'(era6_r) * 15'd400 + 15'(yoe6_r) + 15'(mp6_r >= 4'd10) - 15'd400;
    date_nxt.year  = yr_full[13:0];
    date_nxt.month = (mp6_r < 4'd10) ? mp6_r + 4'd3 : mp6_r - 4'd9;
    date_nxt.day   = 5'(doy6_r - u2r_pkg::month_start(mp6_r) + 9'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[5:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    era1_r <= 5'(era_prod >> u2r_pkg::ERA_K);
    z1_r   <= z;
    era2_r <= era1_r;
    doe2_r <= doe_nxt;
    era3_r <= era2_r;
    doe3_r <= doe2_r;
    num3_r <= num_nxt;
    era4_r <= era3_r;
    doe4_r <= doe3_r;
    yoe4_r <= 9'(y_prod >> 27);
    era5_r <= era4_r;
    yoe5_r <= yoe4_r;
    doy5_r <= 9'(doe4_r - doy_sub);
    era6_r <= era5_r;
    yoe6_r <= yoe5_r;
    doy6_r <= doy5_r;
    mp6_r  <= 4'(mp_prod >> 19);
    date_r <= date_nxt;
  end

  assign out_vld = vld_r[6];
  assign date    = date_r;

endmodule

@@ sim/u2r_checker.sv @@
`timescale 1ns / 100ps
// checker for the unix seconds to rfc3339 converter: predicts each result from the request
// stream and compares it field by field; depends on nothing but the dut ports
module u2r_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [63:0] in_seconds_since_epoch,
  input  logic        out_strobe,
  input  logic        out_valid_res,
  input  logic [13:0] out_year,
  input  logic [3:0]  out_month,
  input  logic [4:0]  out_day_of_month,
  input  logic [4:0]  out_hour,
  input  logic [5:0]  out_minute,
  input  logic [5:0]  out_second,
  input  logic [63:0] out_text_head,
  input  logic [63:0] out_text_middle,
  input  logic [31:0] out_text_tail,
  output int          fail_count,
  output int          pending,
  output int          stamps_done,
  output int          in_range_seen
);

  typedef struct packed {
    logic        ok;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [63:0] head;
    logic [63:0] middle;
    logic [31:0] tail;
  } stamp_t;

  stamp_t stamp_q[$];

  function automatic longint fdiv(longint a, longint b);
    longint q;
    q = a / b;
    if (a % b < 0) q = q - 1;
    return q;
  endfunction

  function automatic logic [15:0] two_digits(int v);
    return {8'(8'h30 + (v / 10) % 10), 8'(8'h30 + v % 10)};
  endfunction

  function automatic stamp_t civil_stamp(logic [63:0] raw);
    stamp_t r;
    longint t, days, sod, z, era, doe, yoe, doy, mp, yr;
    int mo, dy, hh, mi, ss, y;
    t = signed'(raw);
    days = fdiv(t, 86400);
    sod = t - days * 86400;
    z = days + 719468;
    era = fdiv(z, 146097);
    doe = z - era * 146097;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp = (5 * doy + 2) / 153;
    mo = (mp < 10) ? int'(mp + 3) : int'(mp - 9);
    dy = int'(doy - (153 * mp + 2) / 5 + 1);
    yr = yoe + era * 400 + ((mo <= 2) ? 1 : 0);
    r = '0;
    if (yr < 0 || yr > 9999) return r;
    y = int'(yr);
    hh = int'(sod / 3600);
    mi = int'((sod / 60) % 60);
    ss = int'(sod % 60);
    r.ok = 1'b1;
    r.year = 14'(y);
    r.month = 4'(mo);
    r.day = 5'(dy);
    r.hour = 5'(hh);
    r.minute = 6'(mi);
    r.second = 6'(ss);
    r.head = {two_digits(y / 100), two_digits(y % 100), 8'h2d, two_digits(mo), 8'h2d};
    r.middle = {two_digits(dy), 8'h54, two_digits(hh), 8'h3a, two_digits(mi)};
    r.tail = {8'h3a, two_digits(ss), 8'h5a};
    return r;
  endfunction

  task automatic cmp(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    stamps_done = 0;
    in_range_seen = 0;
  end

  always @(posedge clk) begin
    stamp_t e;
    if (rst_n && out_strobe) begin
      if (stamp_q.size() == 0) begin
        $error("result with no request waiting");
        fail_count++;
      end else begin
        e = stamp_q.pop_front();
        cmp("valid_res", e.ok, out_valid_res);
        cmp("year", e.year, out_year);
        cmp("month", e.month, out_month);
        cmp("day_of_month", e.day, out_day_of_month);
        cmp("hour", e.hour, out_hour);
        cmp("minute", e.minute, out_minute);
        cmp("second", e.second, out_second);
        cmp("text_head", e.head, out_text_head);
        cmp("text_middle", e.middle, out_text_middle);
        cmp("text_tail", e.tail, out_text_tail);
        stamps_done++;
        if (e.ok) in_range_seen++;
      end
    end
    if (rst_n && start && !busy) stamp_q.push_back(civil_stamp(in_seconds_since_epoch));
    pending <= stamp_q.size();
  end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// testbench top for unix_seconds_to_rfc3339_utc_top: drives timestamp requests with random
// gaps and gives the verdict; depends on u2r_checker and the dut
module tb;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [63:0] in_seconds_since_epoch;
  logic        out_strobe, out_valid_res;
  logic [13:0] out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day_of_month, out_hour;
  logic [5:0]  out_minute, out_second;
  logic [63:0] out_text_head, out_text_middle;
  logic [31:0] out_text_tail;
  int          fail_count, pending, stamps_done, in_range_seen;
  int          idle_pct;
  int          quiet_cycles;
  bit          timed_out;

  localparam longint T_LO = -64'sd62167219200;
  localparam longint T_HI = 64'sd253402300799;
  localparam int WATCHDOG = 2000;

  unix_seconds_to_rfc3339_utc_top u_dut (.*);

  u2r_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG && !timed_out) begin
      timed_out = 1'b1;
      $display("unix_seconds_to_rfc3339_utc_top test failed");
      $finish;
    end
  end

  // called at a falling edge; leaves start high for the caller to drop or reuse
  task automatic send(logic [63:0] v);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_seconds_since_epoch <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [63:0] rand_stamp();
    int k;
    longint span;
    k = $urandom_range(99);
    if (k < 10) return {$urandom, $urandom};
    if (k < 20) return 64'(T_LO + longint'($urandom_range(200000)) - 100000);
    if (k < 30) return 64'(T_HI + longint'($urandom_range(200000)) - 100000);
    if (k < 40) return 64'(longint'($urandom_range(86400 * 800)) - 86400 * 400);
    span = T_HI - T_LO + 1;
    return 64'(T_LO + longint'({$urandom, $urandom} % 64'(span)));
  endfunction

  initial begin
    logic [63:0] directed[$];
    quiet_cycles = 0;
    timed_out = 1'b0;
    idle_pct = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_seconds_since_epoch = '0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    directed = '{64'd0, 64'hffff_ffff_ffff_ffff, 64'h8000_0000_0000_0000,
                 64'h7fff_ffff_ffff_ffff, 64'(T_LO), 64'(T_LO - 1), 64'(T_HI),
                 64'(T_HI + 1), 64'd86399, 64'd86400, 64'(-64'sd86400),
                 64'(-64'sd86401), 64'd951782400, 64'd951868800, 64'd4107542400,
                 64'd946684799, 64'd1709164800, 64'(-64'sd2208988800),
                 64'(-64'sd12219292800), 64'h5555_5555_5555_5555,
                 64'haaaa_aaaa_aaaa_aaaa, 64'd253402214400};
    foreach (directed[i]) send(directed[i]);
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 15 : (ph == 1) ? 68 : 0;
      repeat (200) send(rand_stamp());
    end
    start <= 1'b0;
    for (int n = 0; n < 1000 && pending != 0; n++) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("converted %0d timestamps, %0d within years 0..9999, under three idle mixes",
             stamps_done, in_range_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("unix_seconds_to_rfc3339_utc_top test passed");
    end else begin
      $display("unix_seconds_to_rfc3339_utc_top test failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/u2r_pkg.sv
sv/u2r_civil.sv
sv/unix_seconds_to_rfc3339_utc_top.sv
sim/u2r_checker.sv
sim/tb.sv
